>>> sv/mfc_pkg.sv
// Shared types and constants for the clamped-border median filter.
// No dependencies; imported by mfc_ctrl, mfc_datapath and the top level.
package mfc_pkg;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 10;
    localparam int CFG_DW  = 11;
    localparam int CFG_IW  = 2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_WINDOW_RADIUS = 2'd2;

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUTPUT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic deliver;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic will_emit;
        logic scan_done;
        logic draining;
    } dp_status_t;

endpackage

>>> sv/mfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/mfc_ctrl.sv
// Controller state machine of the median filter: handshakes and sequencing.
// Depends on mfc_pkg.
module mfc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_stall,
    input  mfc_pkg::dp_status_t status,
    output mfc_pkg::ctrl_cmd_t  cmd,
    output logic               in_stall,
    output logic               out_valid
);
    import mfc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold state across clock edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.will_emit)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.accept  = in_valid;
                cmd.start   = in_valid && status.will_emit;
            end
            ST_SCAN:
            begin
                in_stall = 1'b1;
            end
            ST_OUTPUT:
            begin
                out_valid   = 1'b1;
                cmd.deliver = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> sv/mfc_datapath.sv
// Datapath of the median filter: configuration, raster counters, line store,
// window address generator and bitwise rank selection. Depends on mfc_pkg, mfc_ram.
module mfc_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mfc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [mfc_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        operation,
    input  logic [mfc_pkg::PIX_W-1:0]   pixel_value,
    input  mfc_pkg::ctrl_cmd_t          cmd,
    output mfc_pkg::dp_status_t         status,
    output logic [mfc_pkg::PIX_W-1:0]   median_value,
    output logic [mfc_pkg::POS_W-1:0]   out_column,
    output logic [mfc_pkg::POS_W-1:0]   out_row,
    output logic                        frame_last,
    output logic                        overrun
);
    import mfc_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RH    = $clog2(MAX_HEIGHT);
    localparam int RRW   = $clog2(MAX_RADIUS + 1);
    localparam int SRW   = RRW + 1;
    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = AW + 2;
    localparam int LW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int KW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int BW    = $clog2(PIX_W);

    // Configuration registers
    logic [CFG_DW-1:0] cfg_w_reg;
    logic [CFG_DW-1:0] cfg_h_reg;
    logic [1:0]        cfg_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= CFG_DW'(64);
            cfg_h_reg <= CFG_DW'(64);
            cfg_r_reg <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   cfg_w_reg <= cfg_data;
                CFG_IMAGE_HEIGHT:  cfg_h_reg <= cfg_data;
                CFG_WINDOW_RADIUS: cfg_r_reg <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // Saturate sizes to what the store holds; a zero width or height becomes 1
    logic [WW-1:0]  eff_w;
    logic [HW-1:0]  eff_h;
    logic [RRW-1:0] eff_r;

    always_comb
    begin
        if (cfg_w_reg == '0)
            eff_w = WW'(1);
        else if (32'(cfg_w_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(cfg_w_reg);
        if (cfg_h_reg == '0)
            eff_h = HW'(1);
        else if (32'(cfg_h_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(cfg_h_reg);
        if (32'(cfg_r_reg) > MAX_RADIUS)
            eff_r = RRW'(MAX_RADIUS);
        else
            eff_r = RRW'(cfg_r_reg);
    end

    // Raster state
    logic [CW-1:0] in_col_reg;
    logic [RH-1:0] in_row_reg;
    logic [AW-1:0] in_addr_reg;
    logic [LW-1:0] lin_reg;
    logic [CW-1:0] out_col_reg;
    logic [RH-1:0] out_row_reg;
    logic [AW-1:0] out_addr_reg;
    logic          draining_reg;
    logic          ovr_reg;

    logic          is_pixel;
    logic [LW-1:0] lag;
    logic          in_col_end;
    logic          in_row_end;
    logic          out_col_end;
    logic          out_row_end;
    logic          emit_last;
    logic          will_emit;

    always_comb
    begin
        is_pixel    = (operation == OP_PIXEL);
        lag         = LW'(eff_r) * LW'(eff_w) + LW'(eff_r);
        in_col_end  = (32'(in_col_reg) + 1) >= 32'(eff_w);
        in_row_end  = (32'(in_row_reg) + 1) >= 32'(eff_h);
        out_col_end = (32'(out_col_reg) + 1) >= 32'(eff_w);
        out_row_end = (32'(out_row_reg) + 1) >= 32'(eff_h);
        emit_last   = out_col_end && out_row_end;
        will_emit   = draining_reg || (is_pixel && (lin_reg >= lag));
    end

    // Advance input and output positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_addr_reg  <= '0;
            lin_reg      <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
            draining_reg <= 1'b0;
            ovr_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                ovr_reg <= draining_reg && is_pixel;
                if (!draining_reg && is_pixel)
                begin
                    if (in_col_end && in_row_end)
                    begin
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        in_addr_reg <= '0;
                        lin_reg     <= '0;
                        if (!(will_emit && emit_last))
                        begin
                            draining_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        if (in_col_end)
                        begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + RH'(1);
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + CW'(1);
                        end
                        in_addr_reg <= (in_addr_reg == AW'(DEPTH - 1)) ? '0
                                                                      : in_addr_reg + AW'(1);
                        lin_reg     <= lin_reg + LW'(1);
                    end
                end
            end
            if (cmd.deliver)
            begin
                if (emit_last)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_addr_reg <= '0;
                    draining_reg <= 1'b0;
                end
                else
                begin
                    if (out_col_end)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RH'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                    out_addr_reg <= (out_addr_reg == AW'(DEPTH - 1)) ? '0
                                                                    : out_addr_reg + AW'(1);
                end
            end
        end
    end

    // Window scan sequencer
    logic                  scanning_reg;
    logic                  issuing_reg;
    logic signed [SRW-1:0] dy_reg;
    logic signed [SRW-1:0] dx_reg;
    logic                  v1_reg;
    logic signed [OW-1:0]  off_reg;
    logic                  rd_v_reg;
    logic [BW-1:0]         bit_reg;
    logic [PIX_W-1:0]      prefix_reg;
    logic [KW-1:0]         k_reg;
    logic [KW-1:0]         cnt_reg;

    logic signed [SRW-1:0] pos_r;
    logic signed [SRW-1:0] neg_r;
    logic signed [31:0]    sy;
    logic signed [31:0]    sx;
    logic signed [31:0]    dyc;
    logic signed [31:0]    dxc;
    logic signed [31:0]    off;
    logic signed [31:0]    asum;
    logic [AW-1:0]         rd_addr;
    logic [PIX_W-1:0]      rd_data;
    logic [PIX_W-1:0]      hi_mask;
    logic                  hit;
    logic                  finalize;
    logic                  ram_we;

    // Clamp the window coordinate and form the store offset
    always_comb
    begin
        pos_r = $signed(SRW'(eff_r));
        neg_r = -pos_r;
        sy    = $signed(32'(out_row_reg)) + 32'(dy_reg);
        sx    = $signed(32'(out_col_reg)) + 32'(dx_reg);
        if (sy < 0)
            dyc = -$signed(32'(out_row_reg));
        else if (sy > $signed(32'(eff_h)) - 1)
            dyc = $signed(32'(eff_h)) - 1 - $signed(32'(out_row_reg));
        else
            dyc = 32'(dy_reg);
        if (sx < 0)
            dxc = -$signed(32'(out_col_reg));
        else if (sx > $signed(32'(eff_w)) - 1)
            dxc = $signed(32'(eff_w)) - 1 - $signed(32'(out_col_reg));
        else
            dxc = 32'(dx_reg);
        off = dyc * $signed(32'(eff_w)) + dxc;
    end

    // Wrap the read address into the circular store
    always_comb
    begin
        asum = $signed(32'(out_addr_reg)) + 32'(off_reg);
        if (asum < 0)
            rd_addr = AW'(asum + DEPTH);
        else if (asum >= DEPTH)
            rd_addr = AW'(asum - DEPTH);
        else
            rd_addr = AW'(asum);
    end

    // Compare the read sample against the bits settled so far; form the pass end and store write
    always_comb
    begin
        hi_mask  = (PIX_W'(8'hFF) << bit_reg) << 1;
        hit      = (((rd_data ^ prefix_reg) & hi_mask) == '0) && !rd_data[bit_reg];
        finalize = scanning_reg && !issuing_reg && !v1_reg && !rd_v_reg;
        ram_we   = cmd.accept && !draining_reg && is_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg <= 1'b0;
            issuing_reg  <= 1'b0;
            v1_reg       <= 1'b0;
            rd_v_reg     <= 1'b0;
        end
        else
        begin
            v1_reg   <= issuing_reg;
            rd_v_reg <= v1_reg;
            if (cmd.start)
            begin
                scanning_reg <= 1'b1;
                issuing_reg  <= 1'b1;
            end
            else if (issuing_reg)
            begin
                if (dx_reg == pos_r && dy_reg == pos_r)
                begin
                    issuing_reg <= 1'b0;
                end
            end
            else if (finalize)
            begin
                if (bit_reg == '0)
                    scanning_reg <= 1'b0;
                else
                    issuing_reg <= 1'b1;
            end
        end
    end

    // Payload of the scan: window step, offset, count and settled bits
    always_ff @(posedge clk)
    begin
        off_reg <= OW'(off);
        if (cmd.start)
        begin
            dy_reg     <= neg_r;
            dx_reg     <= neg_r;
            bit_reg    <= BW'(PIX_W - 1);
            prefix_reg <= '0;
            k_reg      <= KW'(2 * 32'(eff_r) * (32'(eff_r) + 1));
            cnt_reg    <= '0;
        end
        else
        begin
            if (issuing_reg)
            begin
                if (dx_reg == pos_r)
                begin
                    dx_reg <= neg_r;
                    if (dy_reg != pos_r)
                        dy_reg <= dy_reg + SRW'(1);
                end
                else
                begin
                    dx_reg <= dx_reg + SRW'(1);
                end
            end
            if (rd_v_reg && hit)
            begin
                cnt_reg <= cnt_reg + KW'(1);
            end
            if (finalize)
            begin
                if (k_reg >= cnt_reg)
                begin
                    k_reg               <= k_reg - cnt_reg;
                    prefix_reg[bit_reg] <= 1'b1;
                end
                cnt_reg <= '0;
                dy_reg  <= neg_r;
                dx_reg  <= neg_r;
                if (bit_reg != '0)
                    bit_reg <= bit_reg - BW'(1);
            end
        end
    end

    mfc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_addr_reg),
        .wdata (pixel_value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Status and result fields
    always_comb
    begin
        status.will_emit = will_emit;
        status.scan_done = finalize && (bit_reg == '0);
        status.draining  = draining_reg;
        median_value     = prefix_reg;
        out_column       = POS_W'(out_col_reg);
        out_row          = POS_W'(out_row_reg);
        frame_last       = emit_last;
        overrun          = ovr_reg;
    end

endmodule

>>> sv/median_filter_clamped.sv
// Top level of the clamped-border square median filter.
// Depends on mfc_pkg, mfc_ctrl, mfc_datapath (and mfc_ram below it).
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  cfg      | cfg_we               | cfg_index, cfg_data
//  in       | in_valid / in_stall  | operation, pixel_value
//  out      | out_valid / out_stall| median_value, out_column, out_row, frame_last,
//           |                      | overrun
//
// A transaction that yields no result is taken while the controller stays idle. One
// that yields a result starts a scan of the n = (2r+1)^2 window samples, and out_valid
// rises once the scan ends: the median is settled one bit per pass over the window,
// each pass reading the line store once per sample through its single read port.
// Reset clears counters and control; the line store is not cleared.
// in_stall stays high from a result-bearing transaction until its result is taken.
module median_filter_clamped #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mfc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [mfc_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [mfc_pkg::PIX_W-1:0]   pixel_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mfc_pkg::PIX_W-1:0]   median_value,
    output logic [mfc_pkg::POS_W-1:0]   out_column,
    output logic [mfc_pkg::POS_W-1:0]   out_row,
    output logic                        frame_last,
    output logic                        overrun
);
    import mfc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    mfc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .pixel_value  (pixel_value),
        .cmd          (cmd),
        .status       (status),
        .median_value (median_value),
        .out_column   (out_column),
        .out_row      (out_row),
        .frame_last   (frame_last),
        .overrun      (overrun)
    );

    // Never take input while a result is on offer
    a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    // One result per scan: a taken result drops valid
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated");

    // The final pixel of a plane ends the drain
    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && frame_last) |=> !status.draining)
        else $error("drain not cleared after final pixel");

endmodule
